// ----- rtl/keyed_high_water_claim_table_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef KEYED_HIGH_WATER_CLAIM_TABLE_UNIT_DEFINES_SVH
`define KEYED_HIGH_WATER_CLAIM_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define KHWCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("claim table check failed");

// Next-cycle implication, off during reset.
`define KHWCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("claim table check failed");

`endif

// ----- rtl/khwct_pkg.sv -----
`default_nettype none
package khwct_pkg;

  localparam int TABLE_ROWS = 32;
  localparam int CNT_W      = $clog2(TABLE_ROWS + 1);
  localparam int KEY_W      = 35;
  localparam int AW         = 3;

  typedef enum logic [1:0] {
    FN_QUERY = 2'd0,
    FN_MARK  = 2'd1,
    FN_CLAIM = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_NEWER = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic [AW-1:0] REG_MAX_INDEX = 3'd0;

  // Search request travelling down the row chain, picking up its result.
  typedef struct packed {
    logic             valid;
    func_t            func;
    logic [KEY_W-1:0] key;
    logic [31:0]      mark;
    logic [31:0]      cip1;
    logic [31:0]      height;
    logic             invalid;
    logic             create;
    logic [CNT_W-1:0] left;
    logic             hit;
    logic             alloc;
    logic             not_newer;
    logic [31:0]      r_mark;
    logic [31:0]      r_cip1;
    logic [31:0]      r_height;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/keyed_high_water_claim_table_unit.sv -----
// Result path: input request register, the row cells, the result register (fin_r),
// then the output register. The search walks the row chain one cell a cycle
// and the next item is taken only once the result has moved to the output register.
// An input transfer may complete while the previous result still waits on out_ready.
// Reset (rst_n low, synchronous): table empty, max_index = 2147483646, no result
// pending; row contents are not cleared and are never read before being written.
`default_nettype none
module keyed_high_water_claim_table_unit import khwct_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  // input channel
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         in_func,
  input  wire  [31:0]        in_fingerprint,
  input  wire                in_testnet,
  input  wire  [1:0]         in_script_type,
  input  wire  [31:0]        in_mark_index,
  input  wire  signed [31:0] in_claim_high,
  input  wire  [31:0]        in_claim_height,
  // result channel
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_usage_found,
  output logic [31:0]        out_usage_high,
  output logic               out_claim_found,
  output logic signed [31:0] out_stored_claim_high,
  output logic [31:0]        out_stored_claim_height,
  output logic [1:0]         out_status,
  // configuration port
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [AW-1:0]      paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t           state_r;
  logic [30:0]      max_index_r;
  logic [CNT_W-1:0] row_count_r;
  req_t             inj_r;
  req_t             fin_r;
  req_t             inj_nxt;
  req_t             chain [TABLE_ROWS+1];
  logic             in_xfer;
  logic             out_free;
  logic             bad_claim;
  logic             has_claim;

  // ---------------------------------------------------------------------------
  // Configuration: single register, max_index, at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= 31'h7FFF_FFFE;
    end else if (psel && penable && pwrite && paddr == REG_MAX_INDEX) begin
      max_index_r <= pwdata[30:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_MAX_INDEX: prdata = {1'b0, max_index_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request build. Claim checks need no table lookup, so they are resolved here
  // and ride along as flags.
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    bad_claim = (in_claim_height == '0)
             || (in_claim_high[31] && in_claim_high != 32'hFFFF_FFFF)
             || (!in_claim_high[31] && in_claim_high[30:0] > max_index_r);
    inj_nxt           = '0;
    inj_nxt.valid     = in_xfer;
    inj_nxt.func      = func_t'(in_func);
    inj_nxt.key       = {in_fingerprint, in_testnet, in_script_type};
    inj_nxt.mark      = in_mark_index;
    inj_nxt.cip1      = in_claim_high + 32'd1;
    inj_nxt.height    = in_claim_height;
    inj_nxt.invalid   = (in_func == FN_CLAIM) && bad_claim;
    inj_nxt.create    = (in_func == FN_MARK) || ((in_func == FN_CLAIM) && !bad_claim);
    inj_nxt.left      = row_count_r;
  end

  // ---------------------------------------------------------------------------
  // Row chain: the request steps one cell per cycle. Each cell matches its row,
  // updates it in place, or allocates itself when it is the first free slot.
  // ---------------------------------------------------------------------------
  assign chain[0] = inj_r;

  for (genvar g = 0; g < TABLE_ROWS; g++) begin : g_row
    khwct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req_in  (chain[g]),
      .req_out (chain[g+1])
    );
  end

  assign has_claim = fin_r.hit && fin_r.r_height != '0;

  // ---------------------------------------------------------------------------
  // Sequencer and result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= '0;
      inj_r.valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      inj_r <= inj_nxt;
      // a parked result reloads the output register in S_HOLD instead
      if (out_valid && out_ready && state_r != S_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (chain[TABLE_ROWS].valid) begin
            fin_r <= chain[TABLE_ROWS];
            if (chain[TABLE_ROWS].func == FN_CLEAR) begin
              row_count_r <= '0;
            end else if (chain[TABLE_ROWS].alloc) begin
              row_count_r <= row_count_r + CNT_W'(1);
            end
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_usage_found         <= fin_r.hit;
            out_usage_high          <= fin_r.hit ? fin_r.r_mark : '0;
            out_claim_found         <= has_claim;
            out_stored_claim_high   <= has_claim ? fin_r.r_cip1 - 32'd1 : 32'hFFFF_FFFF;
            out_stored_claim_height <= has_claim ? fin_r.r_height : '0;
            if (fin_r.invalid) begin
              out_status <= ST_INVALID;
            end else if (fin_r.not_newer) begin
              out_status <= ST_NOT_NEWER;
            end else if (fin_r.create && !fin_r.hit) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= ST_OK;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/khwct_cell.sv -----
`default_nettype none
// One table row plus one stage of the search chain.
module khwct_cell import khwct_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  req_t req_in,
  output req_t req_out
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [31:0]      mark_r, mark_nxt;
  logic [31:0]      cip1_r, cip1_nxt;
  logic [31:0]      height_r, height_nxt;
  req_t             req_r, req_nxt;
  logic             used;
  logic             took;

  always_comb begin
    req_nxt    = req_in;
    key_nxt    = key_r;
    mark_nxt   = mark_r;
    cip1_nxt   = cip1_r;
    height_nxt = height_r;
    used       = req_in.left != '0;
    took       = 1'b0;
    if (req_in.valid) begin
      if (used) begin
        req_nxt.left = req_in.left - CNT_W'(1);
      end
      if (used && !req_in.hit && req_in.func != FN_CLEAR && key_r == req_in.key) begin
        took = 1'b1;
        case (req_in.func)
          FN_MARK: begin
            if (req_in.mark > mark_r) begin
              mark_nxt = req_in.mark;
            end
          end
          FN_CLAIM: begin
            if (!req_in.invalid) begin
              if (height_r != '0 && req_in.height <= height_r) begin
                req_nxt.not_newer = 1'b1;
              end else begin
                cip1_nxt   = req_in.cip1;
                height_nxt = req_in.height;
              end
            end
          end
          default: ;
        endcase
      end else if (!used && !req_in.hit && req_in.create) begin
        // first free slot: allocate
        took          = 1'b1;
        req_nxt.alloc = 1'b1;
        key_nxt       = req_in.key;
        mark_nxt      = (req_in.func == FN_MARK) ? req_in.mark : '0;
        cip1_nxt      = (req_in.func == FN_CLAIM) ? req_in.cip1 : '0;
        height_nxt    = (req_in.func == FN_CLAIM) ? req_in.height : '0;
      end
      if (took) begin
        req_nxt.hit      = 1'b1;
        req_nxt.r_mark   = mark_nxt;
        req_nxt.r_cip1   = cip1_nxt;
        req_nxt.r_height = height_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    mark_r   <= mark_nxt;
    cip1_r   <= cip1_nxt;
    height_r <= height_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r <= req_nxt;
    end
  end

  assign req_out = req_r;

endmodule
`default_nettype wire

// ----- rtl/khwct_chk.sv -----
`default_nettype none
`include "keyed_high_water_claim_table_unit_defines.svh"
module khwct_chk import khwct_pkg::*; (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_usage_found,
  input wire        out_claim_found,
  input wire [1:0]  out_status,
  input wire        pready
);

  `KHWCT_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `KHWCT_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `KHWCT_ASSERT_NOW(a_full_no_row, out_valid && out_status == ST_FULL, !out_usage_found)
  `KHWCT_ASSERT_NOW(a_claim_needs_row, out_valid && out_claim_found, out_usage_found)
  `KHWCT_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)

endmodule

bind keyed_high_water_claim_table_unit khwct_chk u_khwct_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_usage_found (out_usage_found),
  .out_claim_found (out_claim_found),
  .out_status      (out_status),
  .pready          (pready)
);
`default_nettype wire
